/* rtl/core/first_fit_block_allocator_assert.svh */
// Assertion macros for the first-fit block allocator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Checks that a condition holds at every clock edge out of reset.
`define FFBA_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("ffba assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define FFBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffba assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define FFBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffba assertion failed");

`endif

/* rtl/core/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int OFF_W = 20;
  localparam int REQ_W = 20;
  localparam int REL_W = 21;

  localparam int HEAP_BYTES_DEF   = 1048576;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int MAX_BLOCKS_DEF   = 64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_USE,
    OP_FREE,
    OP_SPLIT,
    OP_MERGE
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE_A,
    S_MERGE_B,
    S_MERGE_C
  } state_e;

  typedef struct packed {
    logic             valid;
    logic             free;
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic exact;
    logic split;
    logic match;
    logic pair;
  } flag_t;

endpackage

/* rtl/core/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: control sequencer and cell chain.
// Depends on ffba_pkg, ffba_cell and first_fit_block_allocator_assert.svh.
`timescale 1ns / 1ps

// The heap is kept as an address-ordered row of table cells, one block per
// cell. A transaction is accepted when start is high while busy is low; busy
// then stays high until the result appears. Each result is shown for exactly
// one cycle with done_o high and cannot be held off, so the user must take it
// on that cycle. An allocate walks the chain one cell per cycle from the lowest
// address until the first fitting block or the end of the table. A release
// walks the chain the same way to find its block, then merges a free right
// neighbor and, unless the released block is the first in the table, lets a
// free left neighbor absorb it; a release whose address matches no block
// fails once the walk passes the last block. Splitting or merging moves the
// tail of the table by one cell at once, each cell taking its neighbor's
// contents. A new transaction may be started in the same cycle that the
// previous result is shown.

module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             req_type_i,
  input  logic [REQ_W-1:0] request_bytes_i,
  input  logic [REL_W-1:0] release_offset_i,
  output logic             done_o,
  output logic [OFF_W-1:0] grant_offset_o,
  output logic [1:0]       status_o
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);

  state_e           state_q, state_d;
  op_e              op;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             type_q;
  logic [REQ_W-1:0] req_q;
  logic [REL_W-1:0] rel_q;
  logic             done_q, done_d;
  logic [OFF_W-1:0] grant_q, grant_d;
  status_e          status_q, status_d;

  entry_t ent [MAX_BLOCKS];
  flag_t  flg [MAX_BLOCKS];
  flag_t  cur;
  entry_t cur_ent;
  logic   full;

  // Every cell sees the broadcast operation and pointer, and the contents of
  // both neighbors; the ends of the chain see an empty entry.
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    entry_t prv, nxt;
    if (k == 0) begin : g_first
      assign prv = '0;
    end else begin : g_prev
      assign prv = ent[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_next
      assign nxt = ent[k+1];
    end
    ffba_cell #(
      .IDX          (k),
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .ptr_i       (ptr_q),
      .req_bytes_i (req_q),
      .rel_off_i   (rel_q),
      .prev_i      (prv),
      .next_i      (nxt),
      .ent_o       (ent[k]),
      .flag_o      (flg[k])
    );
  end

  // The pointer stays below MAX_BLOCKS wherever these are used.
  assign cur     = flg[ptr_q[IW-1:0]];
  assign cur_ent = ent[ptr_q[IW-1:0]];
  assign full    = (cnt_q == CW'(MAX_BLOCKS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      cnt_q   <= CW'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grant_q  <= grant_d;
    status_q <= status_d;
    if (start && !busy) begin
      type_q <= req_type_i;
      req_q  <= request_bytes_i;
      rel_q  <= release_offset_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    op       = OP_NONE;
    done_d   = 1'b0;
    grant_d  = grant_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ptr_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ptr_q == cnt_q) begin
          // Walked off the end of the table without a hit.
          done_d   = 1'b1;
          grant_d  = '0;
          status_d = type_q ? ST_BAD_ADDR : ST_NO_FIT;
          state_d  = S_IDLE;
        end else if (!type_q && cur.hit) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          grant_d = '0;
          if (cur.exact) begin
            op       = OP_USE;
            grant_d  = cur_ent.start + OFF_W'(HEADER_BYTES);
            status_d = ST_OK;
          end else if (cur.split && full) begin
            status_d = ST_FULL;
          end else if (cur.split) begin
            op       = OP_SPLIT;
            cnt_d    = cnt_q + CW'(1);
            grant_d  = cur_ent.start + OFF_W'(HEADER_BYTES);
            status_d = ST_OK;
          end else begin
            // The first fitting block is too small to split: fail here.
            status_d = ST_NO_FIT;
          end
        end else if (type_q && cur.match) begin
          op      = OP_FREE;
          state_d = S_MERGE_A;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      S_MERGE_A: begin
        // Absorb the right neighbor if it is free.
        if (cur.pair) begin
          op    = OP_MERGE;
          cnt_d = cnt_q - CW'(1);
        end
        state_d = S_MERGE_B;
      end
      S_MERGE_B: begin
        if (ptr_q == '0) begin
          done_d   = 1'b1;
          grant_d  = '0;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end else begin
          ptr_d   = ptr_q - CW'(1);
          state_d = S_MERGE_C;
        end
      end
      S_MERGE_C: begin
        // Let the left neighbor absorb the released block if it is free.
        if (cur.pair) begin
          op    = OP_MERGE;
          cnt_d = cnt_q - CW'(1);
        end
        done_d   = 1'b1;
        grant_d  = '0;
        status_d = ST_OK;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign grant_offset_o = grant_q;
  assign status_o       = status_q;

`include "first_fit_block_allocator_assert.svh"

  `FFBA_ASSERT_ALWAYS(a_cnt_range, (cnt_q != '0) && (cnt_q <= CW'(MAX_BLOCKS)))
  `FFBA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `FFBA_ASSERT_SAME(a_done_idle, done_o, !busy)
  `FFBA_ASSERT_SAME(a_full_code, done_o && (status_o == ST_FULL), full)

endmodule

/* rtl/core/ffba_cell.sv */
// One table entry of the allocator chain with its local compare logic.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_cell import ffba_pkg::*; #(
  parameter int IDX          = 0,
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  localparam int CW          = $clog2(MAX_BLOCKS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_e              op_i,
  input  logic [CW-1:0]    ptr_i,
  input  logic [REQ_W-1:0] req_bytes_i,
  input  logic [REL_W-1:0] rel_off_i,
  input  entry_t           prev_i,
  input  entry_t           next_i,
  output entry_t           ent_o,
  output flag_t            flag_o
);

  localparam logic [CW-1:0]    MY_IDX  = CW'(IDX);
  localparam logic [OFF_W-1:0] HDR     = OFF_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0] INIT_SZ = OFF_W'(HEAP_BYTES - HEADER_BYTES);

  entry_t        ent_q, ent_d;
  logic [CW-1:0] ptr_nx;

  assign ptr_nx = ptr_i + CW'(1);

  always_comb begin
    ent_d = ent_q;
    case (op_i)
      OP_USE: begin
        if (MY_IDX == ptr_i) ent_d.free = 1'b0;
      end
      OP_FREE: begin
        if (MY_IDX == ptr_i) ent_d.free = 1'b1;
      end
      OP_SPLIT: begin
        if (MY_IDX == ptr_i) begin
          ent_d.bytes = req_bytes_i;
          ent_d.free  = 1'b0;
        end else if (MY_IDX == ptr_nx) begin
          ent_d.valid = 1'b1;
          ent_d.free  = 1'b1;
          ent_d.start = prev_i.start + HDR + req_bytes_i;
          ent_d.bytes = prev_i.bytes - req_bytes_i - HDR;
        end else if (MY_IDX > ptr_nx) begin
          ent_d = prev_i;
        end
      end
      OP_MERGE: begin
        if (MY_IDX == ptr_i) begin
          ent_d.bytes = ent_q.bytes + next_i.bytes + HDR;
        end else if (MY_IDX > ptr_i) begin
          ent_d = next_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.valid <= (IDX == 0);
      ent_q.free  <= (IDX == 0);
      ent_q.start <= '0;
      ent_q.bytes <= (IDX == 0) ? INIT_SZ : '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o        = ent_q;
  assign flag_o.hit   = ent_q.valid && ent_q.free && (ent_q.bytes >= req_bytes_i);
  assign flag_o.exact = (ent_q.bytes == req_bytes_i);
  assign flag_o.split = ({1'b0, ent_q.bytes} >
                         ({1'b0, req_bytes_i} + REL_W'(HEADER_BYTES)));
  assign flag_o.match = ent_q.valid &&
                        (({1'b0, ent_q.start} + REL_W'(HEADER_BYTES)) == rel_off_i);
  assign flag_o.pair  = ent_q.valid && ent_q.free && next_i.valid && next_i.free;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the first-fit block allocator.
// Depends on ffba_pkg and on the first_fit_block_allocator RTL.
`timescale 1ns / 1ps

// Keeps a private copy of the block table and predicts each transaction's
// grant and status. It also holds the queue of results still owed by the block.
class heap_tracker;
  typedef struct {
    bit [19:0]         grant;
    ffba_pkg::status_e status;
  } grant_t;

  localparam int HDR   = 16;
  localparam int SLOTS = 64;
  localparam int HEAP  = 1048576;

  bit [19:0]   hdr_at[SLOTS];
  bit [19:0]   payload[SLOTS];
  bit          is_free[SLOTS];
  int          live;
  grant_t      owed_grants[$];
  int          failures;
  int          seen[4];

  function new();
    foreach (hdr_at[k]) begin
      hdr_at[k]  = '0;
      payload[k] = '0;
      is_free[k] = 1'b0;
    end
    payload[0] = 20'(HEAP - HDR);
    is_free[0] = 1'b1;
    live       = 1;
    failures   = 0;
    foreach (seen[k]) seen[k] = 0;
  endfunction

  function void drop_entry(int idx);
    for (int k = idx; k + 1 < live; k++) begin
      hdr_at[k]  = hdr_at[k+1];
      payload[k] = payload[k+1];
      is_free[k] = is_free[k+1];
    end
    live--;
    hdr_at[live]  = '0;
    payload[live] = '0;
    is_free[live] = 1'b0;
  endfunction

  function void merge_free_runs();
    int k;
    k = 0;
    while (k + 1 < live) begin
      if (is_free[k] && is_free[k+1]) begin
        payload[k] = 20'(int'(payload[k]) + int'(payload[k+1]) + HDR);
        drop_entry(k + 1);
      end else begin
        k++;
      end
    end
  endfunction

  function grant_t allocate(bit [19:0] req);
    grant_t r;
    int     i;
    r.grant  = '0;
    r.status = ffba_pkg::ST_NO_FIT;
    i = 0;
    while (i < live && !(is_free[i] && payload[i] >= req)) i++;
    if (i == live) return r;
    if (payload[i] == req) begin
      is_free[i] = 1'b0;
    end else if (int'(payload[i]) > int'(req) + HDR) begin
      if (live >= SLOTS) begin
        r.status = ffba_pkg::ST_FULL;
        return r;
      end
      for (int k = live; k > i + 1; k--) begin
        hdr_at[k]  = hdr_at[k-1];
        payload[k] = payload[k-1];
        is_free[k] = is_free[k-1];
      end
      hdr_at[i+1]  = 20'(int'(hdr_at[i]) + HDR + int'(req));
      payload[i+1] = 20'(int'(payload[i]) - int'(req) - HDR);
      is_free[i+1] = 1'b1;
      payload[i]   = req;
      is_free[i]   = 1'b0;
      live++;
    end else begin
      return r;
    end
    r.grant  = 20'(int'(hdr_at[i]) + HDR);
    r.status = ffba_pkg::ST_OK;
    return r;
  endfunction

  function grant_t release_block(bit [20:0] off);
    grant_t r;
    r.grant  = '0;
    r.status = ffba_pkg::ST_BAD_ADDR;
    for (int i = 0; i < live; i++) begin
      if (int'(hdr_at[i]) + HDR == int'(off)) begin
        is_free[i] = 1'b1;
        merge_free_runs();
        r.status = ffba_pkg::ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  // Called once per accepted request, in acceptance order.
  function void note_request(bit rel, bit [19:0] req, bit [20:0] off);
    owed_grants.push_back(rel ? release_block(off) : allocate(req));
  endfunction

  function void check_result(bit [19:0] grant, bit [1:0] status);
    grant_t e;
    if (owed_grants.size() == 0) begin
      $error("result with nothing outstanding: grant_offset=%0d status=%0d", grant, status);
      failures++;
      return;
    end
    e = owed_grants.pop_front();
    seen[e.status]++;
    if (grant !== e.grant) begin
      $error("grant_offset: expected %0d, got %0d", e.grant, grant);
      failures++;
    end
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      failures++;
    end
  endfunction

  function int pending();
    return owed_grants.size();
  endfunction

  // Payload size of a randomly chosen free block, or -1 when none is free.
  function int some_free_size();
    int idx[$];
    for (int i = 0; i < live; i++) if (is_free[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return int'(payload[idx[$urandom_range(0, idx.size() - 1)]]);
  endfunction

  function bit [20:0] some_block_offset();
    return 21'(int'(hdr_at[$urandom_range(0, live - 1)]) + HDR);
  endfunction
endclass

module testbench;
  import ffba_pkg::*;

  localparam bit REQ_ALLOC   = 1'b0;
  localparam bit REQ_RELEASE = 1'b1;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             req_type_i;
  logic [REQ_W-1:0] request_bytes_i;
  logic [REL_W-1:0] release_offset_i;
  logic             done_o;
  logic [OFF_W-1:0] grant_offset_o;
  logic [1:0]       status_o;

  heap_tracker heap;
  int          sent;

  first_fit_block_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .request_bytes_i (request_bytes_i),
    .release_offset_i(release_offset_i),
    .done_o          (done_o),
    .grant_offset_o  (grant_offset_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Presents one transaction and returns right after the edge that takes it.
  // The caller must either present the next transaction or drop start in the
  // same time step, so start is never assigned twice at one edge.
  task automatic send_req(bit rel, bit [19:0] req, bit [20:0] off);
    start            <= 1'b1;
    req_type_i       <= rel;
    request_bytes_i  <= req;
    release_offset_i <= off;
    do @(posedge clk_i); while (busy !== 1'b0);
    heap.note_request(rel, req, off);
    sent++;
  endtask

  task automatic pause_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Allocation sizes lean toward the interesting corners: exact fits,
  // near fits that are too small to split, zero bytes and huge requests.
  function automatic bit [19:0] pick_size();
    int sz;
    int pick;
    pick = $urandom_range(0, 99);
    sz   = heap.some_free_size();
    if (pick < 15 && sz >= 0) return 20'(sz);
    if (pick < 25 && sz >= 16) return 20'(sz - int'($urandom_range(1, 16)));
    if (pick < 35) return '0;
    if (pick < 50) return 20'($urandom);
    return 20'($urandom_range(0, 2048));
  endfunction

  function automatic bit [20:0] pick_offset();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return heap.some_block_offset();
    if (pick < 85) return 21'd1048576;
    return 21'($urandom);
  endfunction

  // Results cannot be held off, so every strobe is checked on its own edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) heap.check_result(grant_offset_o, status_o);
  end

  initial begin
    int alloc_pct;
    heap             = new();
    sent             = 0;
    rst_ni           = 1'b0;
    start            = 1'b0;
    req_type_i       = REQ_ALLOC;
    request_bytes_i  = '0;
    release_offset_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero-byte split, ordinary split, a first fit too small
    // to split, an exact fit, no fit at all, bad release addresses, a double
    // release and releases that merge everything back into one block.
    send_req(REQ_ALLOC, 20'd0, 21'd0);
    send_req(REQ_ALLOC, 20'd100, 21'd0);
    send_req(REQ_ALLOC, 20'd1048420, 21'd0);
    send_req(REQ_ALLOC, 20'd1048428, 21'd0);
    send_req(REQ_ALLOC, 20'd0, 21'd0);
    send_req(REQ_ALLOC, 20'hFFFFF, 21'd0);
    send_req(REQ_RELEASE, 20'd0, 21'd0);
    send_req(REQ_RELEASE, 20'd0, 21'd1048576);
    send_req(REQ_RELEASE, 20'd0, 21'h1FFFFF);
    send_req(REQ_RELEASE, 20'hFFFFF, 21'd32);
    send_req(REQ_RELEASE, 20'd0, 21'd32);
    send_req(REQ_RELEASE, 20'd0, 21'd16);
    send_req(REQ_RELEASE, 20'd0, 21'd148);
    send_req(REQ_ALLOC, 20'hFFFFF, 21'h1FFFFF);
    send_req(REQ_ALLOC, 20'd1048560, 21'd0);
    send_req(REQ_RELEASE, 20'd0, 21'd16);

    // Random part in phases of varying allocation pressure, so the table
    // fills up to its limit and then drains again. Outside a long stretch
    // in the middle, the sender pauses before about a third of its requests.
    for (int n = 0; n < 700; n++) begin
      if (n % 100 == 0) alloc_pct = (n / 100) % 2 == 0 ? 85 : 30;
      if (n == 350) begin
        start <= 1'b0;
        while (heap.pending() != 0) @(posedge clk_i);
      end
      if (n < 300 || n >= 420)
        while ($urandom_range(0, 99) < 34) pause_cycles(1);
      if ($urandom_range(0, 99) < alloc_pct)
        send_req(REQ_ALLOC, pick_size(), 21'($urandom));
      else
        send_req(REQ_RELEASE, 20'($urandom), pick_offset());
    end
    start <= 1'b0;

    while (heap.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Sent %0d requests; results ok=%0d no-fit=%0d bad-address=%0d table-full=%0d.",
             sent, heap.seen[ST_OK], heap.seen[ST_NO_FIT], heap.seen[ST_BAD_ADDR],
             heap.seen[ST_FULL]);
    if (heap.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
